// ----- src/ppr_pkg.sv -----
// Shared types and constants of the partial permutation ranker.
package ppr_pkg;

  localparam int unsigned MaxSetDefault = 20;
  localparam int unsigned SizeW         = 5;
  localparam int unsigned ElemW         = 8;
  localparam int unsigned PosW          = 6;
  localparam int unsigned RankW         = 62;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [CfgIdxW-1:0] CfgSetSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeqLength  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLenFromSeq = 2'd2;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StKGtN     = 3'd1,
    StLenNeqK  = 3'd2,
    StLenGtN   = 3'd3,
    StValGeqN  = 3'd4,
    StDup      = 3'd5
  } status_e;

  typedef struct packed {
    logic [SizeW-1:0] set_size;
    logic [SizeW-1:0] seq_length;
    logic             len_from_seq;
  } cfg_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [RankW-1:0] count;
    status_e          status;
  } rank_result_t;

endpackage

// ----- src/ppr_seq.sv -----
// Sequence state of the ranker and its per-element update, applied on each step.
module ppr_seq #(
  parameter int unsigned MAX_SET = ppr_pkg::MaxSetDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ppr_pkg::ElemW-1:0]  element_i,
  input  logic                       last_i,
  input  ppr_pkg::cfg_t              cfg_i,
  output ppr_pkg::rank_result_t      result_o
);

  localparam int unsigned IdxW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;

  logic [MAX_SET-1:0]               used_q, used_d;
  logic [ppr_pkg::PosW-1:0]         pos_q, pos_d;
  logic [ppr_pkg::RankW-1:0]        rank_q, rank_d;
  logic [ppr_pkg::RankW-1:0]        count_q, count_d;
  ppr_pkg::status_e                 err_code_q, err_code_d;
  logic [ppr_pkg::PosW-1:0]         err_pos_q, err_pos_d;
  logic [ppr_pkg::SizeW-1:0]        fpos_q [MAX_SET];

  logic [ppr_pkg::SizeW-1:0] n_eff, k_eff;
  logic [IdxW-1:0]           idx;
  logic                      in_range, val_err, dup, upd;
  logic [MAX_SET-1:0]        below_mask;
  logic [ppr_pkg::SizeW-1:0] below, m;
  logic [ppr_pkg::RankW-1:0] rank_upd, count_upd;
  logic [ppr_pkg::PosW-1:0]  cand_pos, err_pos_upd;
  ppr_pkg::status_e          cand_code, err_code_upd, len_status;
  logic [ppr_pkg::PosW:0]    length;

  assign n_eff = (cfg_i.set_size > ppr_pkg::SizeW'(MAX_SET)) ?
                 ppr_pkg::SizeW'(MAX_SET) : cfg_i.set_size;
  assign k_eff = (cfg_i.seq_length > ppr_pkg::SizeW'(MAX_SET)) ?
                 ppr_pkg::SizeW'(MAX_SET) : cfg_i.seq_length;

  assign idx      = element_i[IdxW-1:0];
  assign in_range = pos_q < ppr_pkg::PosW'(n_eff);
  assign val_err  = element_i >= ppr_pkg::ElemW'(n_eff);
  // The bitmap and the position table are only looked at for values below n.
  assign dup      = !val_err && used_q[idx];
  assign upd      = in_range && !val_err && !dup;

  assign below_mask = (MAX_SET'(1) << idx) - MAX_SET'(1);
  assign below      = ppr_pkg::SizeW'(element_i) -
                      ppr_pkg::SizeW'($countones(used_q & below_mask));
  assign m          = n_eff - ppr_pkg::SizeW'(pos_q);

  assign rank_upd  = upd ? (rank_q * ppr_pkg::RankW'(m) + ppr_pkg::RankW'(below)) : rank_q;
  assign count_upd = upd ? (count_q * ppr_pkg::RankW'(m)) : count_q;

  // A duplicate is charged to the position where its value first appeared.
  assign cand_pos  = val_err ? pos_q : ppr_pkg::PosW'(fpos_q[idx]);
  assign cand_code = ppr_pkg::status_e'(val_err ? ppr_pkg::StValGeqN : ppr_pkg::StDup);

  always_comb begin
    err_pos_upd  = err_pos_q;
    err_code_upd = err_code_q;
    if (in_range && (val_err || dup) && (cand_pos < err_pos_q)) begin
      err_pos_upd  = cand_pos;
      err_code_upd = cand_code;
    end
  end

  assign length = {1'b0, pos_q} + (ppr_pkg::PosW+1)'(1);

  always_comb begin
    len_status = ppr_pkg::StOk;
    if (!cfg_i.len_from_seq) begin
      if (k_eff > n_eff) begin
        len_status = ppr_pkg::StKGtN;
      end else if (length != (ppr_pkg::PosW+1)'(k_eff)) begin
        len_status = ppr_pkg::StLenNeqK;
      end
    end else if (length > (ppr_pkg::PosW+1)'(n_eff)) begin
      len_status = ppr_pkg::StLenGtN;
    end
  end

  always_comb begin
    result_o.status = ppr_pkg::status_e'((len_status != ppr_pkg::StOk) ?
                                         len_status : err_code_upd);
    if (result_o.status == ppr_pkg::StOk) begin
      result_o.rank  = rank_upd;
      result_o.count = count_upd;
    end else begin
      result_o.rank  = '0;
      result_o.count = '0;
    end
  end

  always_comb begin
    used_d     = used_q;
    pos_d      = pos_q;
    rank_d     = rank_q;
    count_d    = count_q;
    err_code_d = err_code_q;
    err_pos_d  = err_pos_q;
    if (step_i) begin
      if (last_i) begin
        used_d     = '0;
        pos_d      = '0;
        rank_d     = '0;
        count_d    = ppr_pkg::RankW'(1);
        err_code_d = ppr_pkg::StOk;
        err_pos_d  = '1;
      end else begin
        if (upd) begin
          used_d[idx] = 1'b1;
        end
        pos_d      = (pos_q != '1) ? pos_q + ppr_pkg::PosW'(1) : pos_q;
        rank_d     = rank_upd;
        count_d    = count_upd;
        err_code_d = err_code_upd;
        err_pos_d  = err_pos_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      pos_q      <= '0;
      rank_q     <= '0;
      count_q    <= ppr_pkg::RankW'(1);
      err_code_q <= ppr_pkg::StOk;
      err_pos_q  <= '1;
    end else begin
      used_q     <= used_d;
      pos_q      <= pos_d;
      rank_q     <= rank_d;
      count_q    <= count_d;
      err_code_q <= err_code_d;
      err_pos_q  <= err_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && upd) begin
      fpos_q[idx] <= ppr_pkg::SizeW'(pos_q);
    end
  end

endmodule

// ----- src/partial_permutation_ranker_unit.sv -----
// Top level of the partial permutation ranker: input stage, state, result register.
//
// Elements of an arrangement enter on the input channel one beat each, with
// last_i marking the final element. Each accepted beat lands in an input
// register; when it moves on, the running rank, the arrangement count and the
// error record are updated in one pass, which is set by the 62-bit by 5-bit
// multiplies of the rank and count. The beat marked last then loads the result
// register, so its rank, count and status show on the output channel once it
// has moved on from the input register. One element can be taken every cycle
// while in_stall_o is low. Elements that are not last keep flowing while a
// result waits; a last element waits in the input register while the result
// register is held by a stalled receiver, and only then is in_stall_o raised.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle. Reset clears the configuration to zero, the sequence state to
// an empty arrangement and both channels to empty; no clearing pass is needed.
module partial_permutation_ranker_unit #(
  parameter int unsigned MAX_SET = ppr_pkg::MaxSetDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ppr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppr_pkg::SizeW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ppr_pkg::ElemW-1:0]    element_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ppr_pkg::RankW-1:0]    rank_o,
  output logic [ppr_pkg::RankW-1:0]    arrangement_count_o,
  output logic [2:0]                   status_o
);

  ppr_pkg::cfg_t             cfg_q;
  logic                      s1_valid_q;
  logic [ppr_pkg::ElemW-1:0] s1_elem_q;
  logic                      s1_last_q;
  logic                      out_valid_q;
  ppr_pkg::rank_result_t     out_q, result;
  logic                      out_free, advance, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppr_pkg::CfgSetSize:    cfg_q.set_size     <= cfg_wdata_i;
        ppr_pkg::CfgSeqLength:  cfg_q.seq_length   <= cfg_wdata_i;
        ppr_pkg::CfgLenFromSeq: cfg_q.len_from_seq <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  // Only a last element needs room in the result register.
  assign advance    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_elem_q <= element_i;
      s1_last_q <= last_i;
    end
  end

  ppr_seq #(
    .MAX_SET(MAX_SET)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .element_i(s1_elem_q),
    .last_i   (s1_last_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign rank_o              = out_q.rank;
  assign arrangement_count_o = out_q.count;
  assign status_o            = out_q.status;

endmodule

// ----- tb/tb_partial_permutation_ranker_unit.sv -----
// Self-checking testbench of the partial permutation ranker unit.
module tb_partial_permutation_ranker_unit;
  import ppr_pkg::*;

  localparam int unsigned MaxSet       = MaxSetDefault;
  localparam int unsigned LongHold     = 150;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned Segments     = 15;
  localparam int unsigned SegmentItems = 50;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             last;
  } element_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgSetSize;
  logic [SizeW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ElemW-1:0]    element_i = '0;
  logic                last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [RankW-1:0]    rank_o;
  logic [RankW-1:0]    arrangement_count_o;
  logic [2:0]          status_o;

  // Configuration as last written, and the predictor's view of the open arrangement.
  logic [SizeW-1:0]    set_size_reg = '0;
  logic [SizeW-1:0]    seq_length_reg = '0;
  logic                len_from_seq_reg = 1'b0;
  logic [MaxSet-1:0]   seen_mask = '0;
  logic [4:0]          first_seen_at [MaxSet];
  logic [PosW-1:0]     beat_pos = '0;
  logic [63:0]         partial_rank = '0;
  logic [63:0]         partial_count = 64'd1;
  status_e             flagged_code = StOk;
  logic [PosW-1:0]     flagged_pos = '1;

  element_beat_t       pending_elements [$];
  element_beat_t       next_beat;
  rank_result_t        expected_results [$];
  rank_result_t        want;
  int unsigned         send_idle_pct = 37;
  int unsigned         recv_idle_pct = 75;
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  logic                hold_request = 1'b0;
  logic                hold_taken = 1'b0;
  int unsigned         hold_left = 0;

  partial_permutation_ranker_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .element_i           (element_i),
    .last_i              (last_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .rank_o              (rank_o),
    .arrangement_count_o (arrangement_count_o),
    .status_o            (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Only the error at the earliest position is kept.
  function automatic void flag_error(status_e code, logic [PosW-1:0] at);
    if (at < flagged_pos) begin
      flagged_pos = at;
      flagged_code = code;
    end
  endfunction

  function automatic void rank_element(logic [ElemW-1:0] elem, logic is_last);
    int unsigned  n, k, m, below, len;
    status_e      st;
    rank_result_t res;
    n = (set_size_reg > MaxSet) ? MaxSet : set_size_reg;
    k = (seq_length_reg > MaxSet) ? MaxSet : seq_length_reg;
    if (beat_pos < n) begin
      if (elem >= n) begin
        flag_error(StValGeqN, beat_pos);
      end else if (seen_mask[elem]) begin
        // A repeated value is charged to where that value first appeared.
        flag_error(StDup, PosW'(first_seen_at[elem]));
      end else begin
        m = n - beat_pos;
        below = elem - $countones(seen_mask & ((MaxSet'(1) << elem) - 1'b1));
        partial_rank = partial_rank * m + below;
        partial_count = partial_count * m;
        seen_mask[elem] = 1'b1;
        first_seen_at[elem] = beat_pos[4:0];
      end
    end
    len = beat_pos + 1;
    if (beat_pos != '1) beat_pos = beat_pos + 1'b1;
    if (is_last) begin
      st = StOk;
      if (!len_from_seq_reg) begin
        if (k > n) st = StKGtN;
        else if (len != k) st = StLenNeqK;
      end else if (len > n) begin
        st = StLenGtN;
      end
      if (st == StOk) st = flagged_code;
      res.status = st;
      res.rank = (st == StOk) ? partial_rank[RankW-1:0] : '0;
      res.count = (st == StOk) ? partial_count[RankW-1:0] : '0;
      expected_results.push_back(res);
      seen_mask = '0;
      beat_pos = '0;
      partial_rank = '0;
      partial_count = 64'd1;
      flagged_code = StOk;
      flagged_pos = '1;
    end
  endfunction

  // Sender: a held beat stays put until the block takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) rank_element(element_i, last_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = pending_elements.pop_front();
          in_valid_i <= 1'b1;
          element_i <= next_beat.element;
          last_i <= next_beat.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and plays the stall pattern.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: no result expected, got rank %0d count %0d status %0d", $time,
                   rank_o, arrangement_count_o, status_o);
        end else begin
          want = expected_results.pop_front();
          if (rank_o !== want.rank || arrangement_count_o !== want.count ||
              status_o !== want.status) begin
            mismatches++;
            $display(
              "%0t: expected rank %0d count %0d status %0d, got rank %0d count %0d status %0d",
              $time, want.rank, want.count, want.status,
              rank_o, arrangement_count_o, status_o);
          end
        end
      end
      if (hold_request != hold_taken) begin
        hold_taken <= hold_request;
        hold_left <= LongHold;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic set_config(input int unsigned n, input int unsigned k, input int unsigned lfs);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgSetSize;
    cfg_wdata_i <= SizeW'(n);
    @(posedge clk_i);
    cfg_idx_i <= CfgSeqLength;
    cfg_wdata_i <= SizeW'(k);
    @(posedge clk_i);
    cfg_idx_i <= CfgLenFromSeq;
    cfg_wdata_i <= SizeW'(lfs);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_size_reg = SizeW'(n);
    seq_length_reg = SizeW'(k);
    len_from_seq_reg = lfs[0];
  endtask

  // Returns once nothing is queued, in flight or expected, and the settling wait is over.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_elements.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic push_arrangement(input int vals[$]);
    element_beat_t b;
    foreach (vals[i]) begin
      b.element = ElemW'(vals[i]);
      b.last = (i == vals.size() - 1);
      pending_elements.push_back(b);
    end
  endtask

  // Mostly well-formed arrangements; some carry a bad value, a repeat, a wrong
  // length, or are runs of noise of up to 70 beats, which can saturate the position counter.
  task automatic push_random_arrangement(input int unsigned n, input int unsigned k,
                                         input int unsigned lfs, output int unsigned len);
    int unsigned target, kind, pick, j;
    int          pool[$];
    int          vals[$];
    target = lfs ? ((n == 0) ? 1 : $urandom_range(n, 1)) : ((k == 0) ? 1 : k);
    kind = $urandom_range(99);
    len = target;
    if (kind >= 88 && kind < 97) len = $urandom_range(target + 2, (target > 2) ? target - 2 : 1);
    else if (kind >= 97) len = $urandom_range(70, 1);
    for (int i = 0; i < n; i++) pool.push_back(i);
    for (int i = 0; i < len; i++) begin
      if (pool.size() != 0 && kind < 97) begin
        pick = $urandom_range(pool.size() - 1);
        vals.push_back(pool[pick]);
        pool.delete(pick);
      end else begin
        vals.push_back($urandom_range(255));
      end
    end
    if (kind >= 70 && kind < 80) begin
      vals[$urandom_range(len - 1)] = $urandom_range(255, n);
    end else if (kind >= 80 && kind < 88 && len > 1) begin
      j = $urandom_range(len - 1, 1);
      vals[j] = vals[$urandom_range(j - 1)];
    end
    push_arrangement(vals);
  endtask

  initial begin
    int unsigned n, k, lfs, pushed, len;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_config(4, 3, 0);
    @(negedge clk_i);
    push_arrangement('{0, 1, 2});
    push_arrangement('{3, 2, 1});
    push_arrangement('{0, 255, 1});
    push_arrangement('{1, 1, 2});
    // The repeat of the first value outranks the later bad value.
    push_arrangement('{2, 9, 2});
    push_arrangement('{9, 0, 0});
    push_arrangement('{0, 1});
    wait_drained();
    set_config(4, 5, 0);
    @(negedge clk_i);
    push_arrangement('{0});
    wait_drained();
    set_config(4, 0, 1);
    @(negedge clk_i);
    push_arrangement('{0, 1, 2, 3});
    push_arrangement('{3, 2, 1, 0, 7});
    wait_drained();
    set_config(0, 0, 0);
    @(negedge clk_i);
    push_arrangement('{0});
    wait_drained();

    for (int seg = 0; seg < Segments; seg++) begin
      if (seg == Segments / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 37;
      end
      if (seg == 2 * Segments / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: begin
          n = 20; k = 20; lfs = 0;
        end
        1: begin
          n = 20; k = $urandom_range(20); lfs = 1;
        end
        2: begin
          n = 1; k = 1; lfs = 0;
        end
        3: begin
          n = 31; k = 31; lfs = $urandom_range(1);
        end
        4: begin
          n = 0; k = $urandom_range(31); lfs = $urandom_range(1);
        end
        default: begin
          n = $urandom_range(20);
          k = ($urandom_range(3) == 0) ? $urandom_range(31) : n;
          lfs = $urandom_range(1);
        end
      endcase
      set_config(n, k, lfs);
      @(negedge clk_i);
      pushed = 0;
      while (pushed < SegmentItems) begin
        push_random_arrangement((n > MaxSet) ? MaxSet : n, (k > MaxSet) ? MaxSet : k, lfs, len);
        pushed += len;
      end
      // A long receiver hold-off while the sender keeps offering beats.
      if (seg == 2 * Segments / 3) hold_request = ~hold_request;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
